// ===== sv/hlp_pkg.sv =====
// Package: shared types, constants and elaboration-time table functions for the palette generator.
package hlp_pkg;

    localparam int PhaseBitsDefault = 16;
    localparam int CosFracDefault   = 15;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    localparam int IdxW     = 11;
    localparam int TurnSteps = 1400;
    localparam logic [IdxW:0] TurnWide = 12'd1400;

    localparam int LumaSumW       = 12;
    localparam int LumaRecip      = 4370;
    localparam int LumaRecipShift = 16;
    localparam int LumaProdW      = LumaSumW + 13;

    localparam logic [7:0] BlackReset     = 8'h00;
    localparam logic [7:0] WhiteReset     = 8'he0;
    localparam logic [7:0] IntensityReset = 8'd80;
    localparam logic [7:0] ShiftReset     = 8'd40;

    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam longint unsigned OneQ30    = 64'd1 << 30;

    typedef enum logic [CfgIdxW-1:0] {
        CfgBlack     = 2'd0,
        CfgWhite     = 2'd1,
        CfgIntensity = 2'd2,
        CfgShift     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_en;

    // (-7 * shift) mod 1400
    function automatic logic [IdxW-1:0] shift_offset(input logic [7:0] s);
        logic signed [IdxW:0] sx;
        logic signed [IdxW:0] n;
        sx = signed'({{4{s[7]}}, s});
        n  = sx - (sx <<< 3);
        if (n < 0) begin
            n = n + signed'(TurnWide);
        end
        return n[IdxW-1:0];
    endfunction

    // (100 * hue) mod 1400
    function automatic logic [IdxW-1:0] hue_offset(input logic [3:0] h);
        logic [3:0] hm;
        hm = (h >= 4'd14) ? h - 4'd14 : h;
        return IdxW'({7'd0, hm} * 11'd100);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'h00;
        end else if (v > 11'sd255) begin
            res = 8'hff;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    function automatic longint unsigned idx_phase(input int k, input int pbits);
        longint unsigned turn;
        longint unsigned num;
        turn = 64'd1 << pbits;
        num  = 64'd2 * longint'(k) * turn + 64'd1400;
        return (num / 64'd2800) & (turn - 64'd1);
    endfunction

    function automatic longint unsigned phase_minus_third(input longint unsigned phase,
                                                          input int pbits);
        longint unsigned turn;
        longint unsigned third;
        turn  = 64'd1 << pbits;
        third = (64'd2 * turn + 64'd3) / 64'd6;
        return (phase + turn - third) & (turn - 64'd1);
    endfunction

    function automatic longint to_qf(input longint v, input int fbits);
        return (v + (64'sd1 <<< (29 - fbits))) >>> (30 - fbits);
    endfunction

    function automatic longint cos_at(input longint unsigned phase, input int pbits,
                                      input int fbits);
        longint unsigned mask;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint c;
        longint s;
        longint res;
        mask = (64'd1 << (pbits - 2)) - 64'd1;
        quad = (phase >> (pbits - 2)) & 64'd3;
        r    = phase & mask;
        x    = (r * HalfPiQ30) >> (pbits - 2);
        x2   = (x * x) >> 30;
        tc   = OneQ30;
        ts   = x;
        c    = longint'(tc);
        s    = longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd2;   ts = ((ts * x2) >> 30) / 64'd6;
        c  = c - longint'(tc);            s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd12;  ts = ((ts * x2) >> 30) / 64'd20;
        c  = c + longint'(tc);            s  = s + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd30;  ts = ((ts * x2) >> 30) / 64'd42;
        c  = c - longint'(tc);            s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd56;  ts = ((ts * x2) >> 30) / 64'd72;
        c  = c + longint'(tc);            s  = s + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd90;  ts = ((ts * x2) >> 30) / 64'd110;
        c  = c - longint'(tc);            s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd132; ts = ((ts * x2) >> 30) / 64'd156;
        c  = c + longint'(tc);            s  = s + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd182; ts = ((ts * x2) >> 30) / 64'd210;
        c  = c - longint'(tc);            s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd240; ts = ((ts * x2) >> 30) / 64'd272;
        c  = c + longint'(tc);            s  = s + longint'(ts);
        if (c < 0) begin
            c = 0;
        end
        if (s < 0) begin
            s = 0;
        end
        c = to_qf(c, fbits);
        s = to_qf(s, fbits);
        case (quad)
            64'd0:   res = c;
            64'd1:   res = -s;
            64'd2:   res = -c;
            default: res = s;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/hlp_cos_rom.sv =====
// Cosine pair ROM: both chroma cosines for each phase step, registered read.
module hlp_cos_rom
    import hlp_pkg::*;
#(
    parameter int PHASE_BITS        = PhaseBitsDefault,
    parameter int COS_FRACTION_BITS = CosFracDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rd_en,
    input  logic [IdxW-1:0]                    i_addr,
    output logic signed [COS_FRACTION_BITS+1:0] o_cos_r,
    output logic signed [COS_FRACTION_BITS+1:0] o_cos_b
);

    localparam int CosW = COS_FRACTION_BITS + 2;

    logic [2*CosW-1:0] w_rom [TurnSteps];
    logic [2*CosW-1:0] r_data;

    for (genvar g = 0; g < TurnSteps; g++) begin : g_rom
        localparam longint unsigned PhaseR = idx_phase(g, PHASE_BITS);
        localparam longint unsigned PhaseB = phase_minus_third(PhaseR, PHASE_BITS);
        localparam longint CosR = cos_at(PhaseR, PHASE_BITS, COS_FRACTION_BITS);
        localparam longint CosB = cos_at(PhaseB, PHASE_BITS, COS_FRACTION_BITS);
        assign w_rom[g] = {CosB[CosW-1:0], CosR[CosW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_cos_r = signed'(r_data[CosW-1:0]);
    assign o_cos_b = signed'(r_data[2*CosW-1:CosW]);

endmodule

// ===== sv/hlp_mix.sv =====
// Chroma scaling, luma division and colour mixing with clamp: stages two and three.
module hlp_mix
    import hlp_pkg::*;
#(
    parameter int COS_FRACTION_BITS = CosFracDefault
) (
    input  logic                                i_clk,
    input  t_pipe_en                            i_en,
    input  logic                                i_chroma_on,
    input  logic [LumaSumW-1:0]                 i_luma_sum,
    input  logic signed [COS_FRACTION_BITS+1:0] i_cos_r,
    input  logic signed [COS_FRACTION_BITS+1:0] i_cos_b,
    input  logic [7:0]                          i_intensity,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue
);

    localparam int CosW  = COS_FRACTION_BITS + 2;
    localparam int MagW  = COS_FRACTION_BITS + 1;
    localparam int ProdW = MagW + 8;

    logic [CosW-1:0]      w_cr_abs;
    logic [CosW-1:0]      w_cb_abs;
    logic [ProdW-1:0]     w_cr_prod;
    logic [ProdW-1:0]     w_cb_prod;
    logic [LumaProdW-1:0] w_y_prod;

    logic [7:0] r_y;
    logic [7:0] r_cr_mag;
    logic [7:0] r_cb_mag;
    logic       r_cr_neg;
    logic       r_cb_neg;

    logic signed [10:0] w_y_s;
    logic signed [10:0] w_cr_s;
    logic signed [10:0] w_cb_s;
    logic signed [10:0] w_red;
    logic signed [10:0] w_green;
    logic signed [10:0] w_blue;

    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;

    always_comb begin
        w_cr_abs  = i_cos_r[CosW-1] ? CosW'(-i_cos_r) : CosW'(i_cos_r);
        w_cb_abs  = i_cos_b[CosW-1] ? CosW'(-i_cos_b) : CosW'(i_cos_b);
        w_cr_prod = ProdW'(w_cr_abs[MagW-1:0]) * ProdW'(i_intensity);
        w_cb_prod = ProdW'(w_cb_abs[MagW-1:0]) * ProdW'(i_intensity);
        w_y_prod  = LumaProdW'(i_luma_sum) * LumaProdW'(LumaRecip);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_y      <= w_y_prod[LumaRecipShift +: 8];
            r_cr_mag <= i_chroma_on ? w_cr_prod[COS_FRACTION_BITS +: 8] : 8'd0;
            r_cb_mag <= i_chroma_on ? w_cb_prod[COS_FRACTION_BITS +: 8] : 8'd0;
            r_cr_neg <= i_cos_r[CosW-1];
            r_cb_neg <= i_cos_b[CosW-1];
        end
    end

    always_comb begin
        w_y_s   = signed'({3'b000, r_y});
        w_cr_s  = r_cr_neg ? -signed'({3'b000, r_cr_mag}) : signed'({3'b000, r_cr_mag});
        w_cb_s  = r_cb_neg ? -signed'({3'b000, r_cb_mag}) : signed'({3'b000, r_cb_mag});
        w_red   = w_y_s + w_cr_s;
        w_green = w_y_s - w_cr_s - w_cb_s;
        w_blue  = w_y_s + w_cb_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_red   <= clamp8(w_red);
            r_green <= clamp8(w_green);
            r_blue  <= clamp8(w_blue);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== sv/hue_luma_palette_generator.sv =====
// Top level: hue and luma step to clamped red, green and blue through a cosine ROM pipeline.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata[3:0] hue, [7:4] luma_step
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata[7:0] red, [15:8] green, [23:16] blue
//   cfg       in   i_cfg_we                         i_cfg_addr index, i_cfg_wdata value
//
// One item per cycle unless m_axis stalls; the ROM read, scaling and mix are each registered.
// The single-port cosine ROM is read once per item.
// Stages advance independently, so a stalled output only blocks input once all stages are full.
// Reset is synchronous: it clears the valid flags and loads the config registers; the ROM is constant.
module hue_luma_palette_generator
    import hlp_pkg::*;
#(
    parameter int PHASE_BITS        = PhaseBitsDefault,
    parameter int COS_FRACTION_BITS = CosFracDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [3:0] hue, [7:4] luma_step
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int CosW = COS_FRACTION_BITS + 2;

    logic [7:0]      r_black;
    logic [7:0]      r_white;
    logic [7:0]      r_intensity;
    logic [IdxW-1:0] r_shift_off;

    t_pipe_en w_en;
    logic     r_valid1;
    logic     r_valid2;
    logic     r_valid3;

    logic [3:0]          w_hue;
    logic [3:0]          w_luma_step;
    logic [IdxW:0]       w_idx_sum;
    logic [IdxW-1:0]     w_idx;
    logic [LumaSumW-1:0] w_luma_sum;

    logic                r_chroma_on;
    logic [LumaSumW-1:0] r_luma_sum;

    logic signed [CosW-1:0] w_cos_r;
    logic signed [CosW-1:0] w_cos_b;

    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black     <= BlackReset;
            r_white     <= WhiteReset;
            r_intensity <= IntensityReset;
            r_shift_off <= shift_offset(ShiftReset);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CfgBlack:     r_black     <= i_cfg_wdata;
                CfgWhite:     r_white     <= i_cfg_wdata;
                CfgIntensity: r_intensity <= i_cfg_wdata;
                CfgShift:     r_shift_off <= shift_offset(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        w_en.en3 = !r_valid3 || m_axis_tready;
        w_en.en2 = !r_valid2 || w_en.en3;
        w_en.en1 = !r_valid1 || w_en.en2;
    end

    assign s_axis_tready = w_en.en1;
    assign m_axis_tvalid = r_valid3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (w_en.en1) begin
                r_valid1 <= s_axis_tvalid;
            end
            if (w_en.en2) begin
                r_valid2 <= r_valid1;
            end
            if (w_en.en3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    always_comb begin
        w_hue       = s_axis_tdata[3:0];
        w_luma_step = s_axis_tdata[7:4];
        w_idx_sum   = {1'b0, hue_offset(w_hue)} + {1'b0, r_shift_off};
        w_idx       = (w_idx_sum >= TurnWide) ? IdxW'(w_idx_sum - TurnWide)
                                              : w_idx_sum[IdxW-1:0];
        w_luma_sum  = ({4'd0, r_white} * {8'd0, w_luma_step})
                    + ({4'd0, r_black} * {8'd0, 4'd15 - w_luma_step});
    end

    always_ff @(posedge i_clk) begin
        if (w_en.en1) begin
            r_chroma_on <= (w_hue != 4'd0);
            r_luma_sum  <= w_luma_sum;
        end
    end

    hlp_cos_rom #(
        .PHASE_BITS        (PHASE_BITS),
        .COS_FRACTION_BITS (COS_FRACTION_BITS)
    ) u_cos_rom (
        .i_clk   (i_clk),
        .i_rd_en (w_en.en1),
        .i_addr  (w_idx),
        .o_cos_r (w_cos_r),
        .o_cos_b (w_cos_b)
    );

    hlp_mix #(
        .COS_FRACTION_BITS (COS_FRACTION_BITS)
    ) u_mix (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_chroma_on (r_chroma_on),
        .i_luma_sum  (r_luma_sum),
        .i_cos_r     (w_cos_r),
        .i_cos_b     (w_cos_b),
        .i_intensity (r_intensity),
        .o_red       (w_red),
        .o_green     (w_green),
        .o_blue      (w_blue)
    );

    assign m_axis_tdata = {w_blue, w_green, w_red};

`ifndef SYNTH
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_valid1 && r_valid2 && r_valid3 && !m_axis_tready))
        else $error("input stalled with a free stage");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid1 && !w_en.en2) |=> r_valid1)
        else $error("stage one item lost while blocked");

    a_stage2_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid1 && w_en.en2) |=> r_valid2)
        else $error("stage one item not passed on");

    a_rom_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en.en1 |=> ($stable(w_cos_r) && $stable(w_cos_b)))
        else $error("cosine data changed while stage one blocked");
`endif

endmodule
